/* sv/chained_hash_map_engine_assert.svh */
// Assertion macros shared by the checker of the hash map engine.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CHAINED_HASH_MAP_ENGINE_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CHME_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHME_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

/* sv/chme_pkg.sv */
// Package of the chained hash map engine: opcodes, status codes, sizes and hash.
// Depends on nothing.
package chme_pkg;
   localparam int unsigned BUCKETS_DEF    = 256;
   localparam int unsigned ENTRIES_DEF    = 256;
   localparam int unsigned KEY_BITS_DEF   = 32;
   localparam int unsigned VALUE_BITS_DEF = 32;

   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_REMOVED   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_CLEARED   = 3'd6;

   localparam logic [31:0] HASH_MUL  = 32'h27d4eb2d;
   localparam logic [31:0] HASH_SEED = 32'd61;

   // First half of the integer hash, before the multiply.
   function automatic logic [31:0] hash_pre(input logic [31:0] k_in);
      logic [31:0] k;
      k = (k_in ^ HASH_SEED) ^ (k_in >> 16);
      k = k + (k << 3);
      k = k ^ (k >> 4);
      return k;
   endfunction

   // Second half of the hash, after the multiply.
   function automatic logic [31:0] hash_post(input logic [31:0] k_in);
      return k_in ^ (k_in >> 15);
   endfunction
endpackage

/* sv/chained_hash_map_engine.sv */
// Put, get and remove go from an accepted word through the hash state, the probe's
// travel along the cell row, then the update and output states to rsp_tvalid; a
// clear skips the row.
// Throughput: one word at a time; req_tready returns the cycle after the result is
// taken.
// Reset is synchronous, active high; it empties every cell and the entry count.
module chained_hash_map_engine
   import chme_pkg::*;
#(
   parameter int unsigned BUCKETS    = BUCKETS_DEF,
   parameter int unsigned ENTRIES    = ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode [1:0], key [33:2], value [65:34], zero fill to 72 bits
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status [2:0], read_value [34:3], entry_total [43:35], zero fill to 48 bits
   output logic [47:0] rsp_tdata
);
   // Cells match on bucket and key, so the chain order is kept implicitly.
   localparam int unsigned KEY_BITS   = KEY_BITS_DEF;
   localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
   localparam int unsigned BKT_BITS = $clog2(BUCKETS);
   localparam int unsigned CNT_BITS = $clog2(ENTRIES + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_HASH = 5'b00010, S_WALK = 5'b00100,
      S_ACT  = 5'b01000, S_OUT  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [31:0]           pre_ff;
   logic [BKT_BITS-1:0]   bkt_ff;
   logic                  start_ff;
   logic [ENTRIES-1:0]    hitmask_ff;
   logic                  hit_ff;
   logic [VALUE_BITS-1:0] rdv_ff;
   logic [CNT_BITS-1:0]   occ_ff;
   logic [2:0]            st_ff;
   logic [31:0]           rv_ff;
   logic [31:0]           prod;
   logic [31:0]           h;
   logic                  done, hit;
   logic [VALUE_BITS-1:0] rdv;
   logic [ENTRIES-1:0]    busy, hits, write, drop, freemask;
   logic                  clear, fill;
   logic                  walk_end;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {4'd0, 9'(occ_ff), rv_ff, st_ff};

   // First register stage folds the key and applies the pre-multiply steps.
   assign prod = pre_ff * HASH_MUL;
   assign h    = hash_post(prod);

   // Lowest free cell receives a new entry.
   assign freemask = ~busy & (busy + ENTRIES'(1));

   // Clear needs no walk; the row's done ends the walk for the other ops.
   assign walk_end = done || (state_ff == S_WALK && op_ff == OP_CLEAR);

   always_comb begin
      state_in = state_ff;
      clear = 1'b0; fill = 1'b0; write = '0; drop = '0;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_HASH;
         S_HASH: state_in = S_WALK;
         S_WALK: if (walk_end) state_in = S_ACT;
         S_ACT: begin
            state_in = S_OUT;
            case (op_ff)
               OP_CLEAR: clear = 1'b1;
               OP_PUT: begin
                  if (hit_ff) write = hitmask_ff;
                  else if (occ_ff < CNT_BITS'(ENTRIES)) begin
                     write = freemask; fill = 1'b1;
                  end
               end
               OP_REMOVE: if (hit_ff) drop = hitmask_ff;
               default: ;
            endcase
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == S_HASH) && (op_ff != OP_CLEAR);
         if (state_ff == S_ACT) begin
            case (op_ff)
               OP_CLEAR: occ_ff <= '0;
               OP_PUT: if (!hit_ff && occ_ff < CNT_BITS'(ENTRIES)) occ_ff <= occ_ff + 1'b1;
               OP_REMOVE: if (hit_ff && occ_ff != '0) occ_ff <= occ_ff - 1'b1;
               default: ;
            endcase
         end
      end
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff  <= req_tdata[1:0];
         key_ff <= KEY_BITS'(req_tdata[33:2]);
         val_ff <= VALUE_BITS'(req_tdata[65:34]);
         pre_ff <= hash_pre(req_tdata[33:2]);
      end
      if (state_ff == S_HASH) bkt_ff <= h[BKT_BITS-1:0];
      if (start_ff) hitmask_ff <= '0;
      else hitmask_ff <= hitmask_ff | hits;
      if (done) begin
         hit_ff <= hit;
         rdv_ff <= rdv;
      end
      if (state_ff == S_HASH && op_ff == OP_CLEAR) begin
         // Clear skips the walk; S_WALK moves straight on to S_ACT.
         hit_ff <= 1'b0;
      end
      if (state_ff == S_ACT) begin
         rv_ff <= (op_ff == OP_GET && hit_ff) ? 32'(rdv_ff) : 32'd0;
         case (op_ff)
            OP_CLEAR: st_ff <= ST_CLEARED;
            OP_PUT: st_ff <= hit_ff ? ST_UPDATED
                           : (occ_ff < CNT_BITS'(ENTRIES) ? ST_INSERTED : ST_FULL);
            OP_GET: st_ff <= hit_ff ? ST_FOUND : ST_NOT_FOUND;
            default: st_ff <= hit_ff ? ST_REMOVED : ST_NOT_FOUND;
         endcase
      end
   end

   chme_row #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
              .BKT_BITS(BKT_BITS))
      u_row (
         .clock(clock), .reset(reset),
         .start_i(start_ff), .key_i(key_ff), .bkt_i(bkt_ff), .val_i(val_ff),
         .done_o(done), .hit_o(hit), .rd_val_o(rdv),
         .clear_i(clear), .write_i(write), .fill_i(fill), .drop_i(drop),
         .busy_o(busy), .hits_o(hits));
endmodule

/* sv/chme_cell.sv */
// One entry cell of the hash map row: holds key, value, bucket and valid flag.
// Depends on chme_pkg. Matching is by bucket and key, so chains are implicit.
module chme_cell
   import chme_pkg::*;
#(
   parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
   parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
   parameter int unsigned BKT_BITS   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Probe traveling along the row.
   input  logic                  probe_vld_in_i,
   input  logic [KEY_BITS-1:0]   probe_key_i,
   input  logic [BKT_BITS-1:0]   probe_bkt_i,
   input  logic                  probe_hit_i,
   input  logic [VALUE_BITS-1:0] probe_val_i,
   output logic                  probe_vld_o,
   output logic [KEY_BITS-1:0]   probe_key_o,
   output logic [BKT_BITS-1:0]   probe_bkt_o,
   output logic                  probe_hit_o,
   output logic [VALUE_BITS-1:0] probe_val_o,
   // Commands from the controller.
   input  logic                  clear_i,
   input  logic                  write_i,
   input  logic                  fill_i,
   input  logic                  drop_i,
   input  logic [KEY_BITS-1:0]   wr_key_i,
   input  logic [BKT_BITS-1:0]   wr_bkt_i,
   input  logic [VALUE_BITS-1:0] wr_val_i,
   output logic                  busy_o
);
   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [BKT_BITS-1:0]   bkt_ff, bkt_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                  pvld_ff;
   logic [KEY_BITS-1:0]   pkey_ff;
   logic [BKT_BITS-1:0]   pbkt_ff;
   logic                  phit_ff;
   logic [VALUE_BITS-1:0] pval_ff;
   logic                  match;

   assign match = valid_ff && !probe_hit_i && (key_ff == probe_key_i)
                  && (bkt_ff == probe_bkt_i);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      bkt_in   = bkt_ff;
      val_in   = val_ff;
      if (clear_i) begin
         valid_in = 1'b0;
      end else if (drop_i) begin
         valid_in = 1'b0;
      end else if (write_i) begin
         val_in = wr_val_i;
         if (fill_i) begin
            valid_in = 1'b1;
            key_in   = wr_key_i;
            bkt_in   = wr_bkt_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pvld_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pvld_ff  <= probe_vld_in_i;
      end
      key_ff  <= key_in;
      bkt_ff  <= bkt_in;
      val_ff  <= val_in;
      pkey_ff <= probe_key_i;
      pbkt_ff <= probe_bkt_i;
      phit_ff <= probe_hit_i || match;
      pval_ff <= match ? val_ff : probe_val_i;
   end

   assign probe_vld_o = pvld_ff;
   assign probe_key_o = pkey_ff;
   assign probe_bkt_o = pbkt_ff;
   assign probe_hit_o = phit_ff;
   assign probe_val_o = pval_ff;
   assign busy_o      = valid_ff;
endmodule

/* sv/chme_row.sv */
// Row of entry cells with a per-cell hit flag captured as the probe passes.
// Depends on chme_pkg and chme_cell.
module chme_row
   import chme_pkg::*;
#(
   parameter int unsigned ENTRIES    = ENTRIES_DEF,
   parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
   parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
   parameter int unsigned BKT_BITS   = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start_i,
   input  logic [KEY_BITS-1:0]        key_i,
   input  logic [BKT_BITS-1:0]        bkt_i,
   input  logic [VALUE_BITS-1:0]      val_i,
   output logic                       done_o,
   output logic                       hit_o,
   output logic [VALUE_BITS-1:0]      rd_val_o,
   input  logic                       clear_i,
   input  logic [ENTRIES-1:0]         write_i,
   input  logic                       fill_i,
   input  logic [ENTRIES-1:0]         drop_i,
   output logic [ENTRIES-1:0]         busy_o,
   output logic [ENTRIES-1:0]         hits_o
);
   logic                  vld  [ENTRIES+1];
   logic [KEY_BITS-1:0]   key  [ENTRIES+1];
   logic [BKT_BITS-1:0]   bkt  [ENTRIES+1];
   logic                  hit  [ENTRIES+1];
   logic [VALUE_BITS-1:0] val  [ENTRIES+1];
   logic [ENTRIES-1:0]    hit_in_q;

   assign vld[0] = start_i;
   assign key[0] = key_i;
   assign bkt[0] = bkt_i;
   assign hit[0] = 1'b0;
   assign val[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      chme_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS), .BKT_BITS(BKT_BITS))
         u_cell (
            .clock(clock), .reset(reset),
            .probe_vld_in_i(vld[g]), .probe_key_i(key[g]), .probe_bkt_i(bkt[g]),
            .probe_hit_i(hit[g]), .probe_val_i(val[g]),
            .probe_vld_o(vld[g+1]), .probe_key_o(key[g+1]), .probe_bkt_o(bkt[g+1]),
            .probe_hit_o(hit[g+1]), .probe_val_o(val[g+1]),
            .clear_i(clear_i), .write_i(write_i[g]), .fill_i(fill_i),
            .drop_i(drop_i[g]), .wr_key_i(key_i), .wr_bkt_i(bkt_i), .wr_val_i(val_i),
            .busy_o(busy_o[g]));
   end

   // Hit mask: the probe entering cell g does not yet carry a hit from it,
   // so compare the outgoing flag with a registered copy of the incoming one.
   for (genvar h = 0; h < ENTRIES; h++) begin : g_hq
      always_ff @(posedge clock) begin
         hit_in_q[h] <= hit[h];
      end
      assign hits_o[h] = hit[h+1] && !hit_in_q[h] && vld[h+1];
   end

   assign done_o   = vld[ENTRIES];
   assign hit_o    = hit[ENTRIES];
   assign rd_val_o = val[ENTRIES];
endmodule

/* sv/chme_checker.sv */
// Port-level checker for the chained hash map engine, bound to the top level.
// Depends on chained_hash_map_engine_assert.svh.
`include "chained_hash_map_engine_assert.svh"
module chme_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   `CHME_ASSERT_IMP(a_excl, clock, reset, rsp_tvalid, !req_tready)
   `CHME_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `CHME_ASSERT_IMP(a_status, clock, reset, rsp_tvalid, rsp_tdata[2:0] != 3'd7)
   `CHME_ASSERT_IMP(a_total, clock, reset, rsp_tvalid, rsp_tdata[43:35] <= 9'd256)
endmodule

bind chained_hash_map_engine chme_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
